// ===== src/ssba_pkg.sv =====
`default_nettype none

package ssba_pkg;

  localparam int unsigned NUM_FILES_DEF = 4;
  localparam int unsigned MAX_PAGES_DEF = 4096;

  localparam int unsigned CFG_FILES  = 4;
  localparam int unsigned FSEL_W     = $clog2(CFG_FILES);
  localparam int unsigned FILE_W     = 4;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned OFF_SPAN   = 1 << OFF_W;
  localparam int unsigned ENTRY_W    = 23;
  localparam int unsigned OFF_LSB    = 11;
  localparam int unsigned PAGES_W    = 13;
  localparam int unsigned TOTAL_W    = 15;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_BADARG   = 2'd2,
    STAT_NOTALLOC = 2'd3
  } status_e;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  idx;
    logic [WORD_W-1:0] onehot;
  } ffz_t;

endpackage

`default_nettype wire

// ===== src/ssba_bitmap.sv =====
`default_nettype none

module ssba_bitmap #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [ADDR_W-1:0]         rd_addr_i,
  output logic      [ssba_pkg::WORD_W-1:0] rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [ADDR_W-1:0]         wr_addr_i,
  input  wire logic [ssba_pkg::WORD_W-1:0] wr_data_i
);
  import ssba_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/ssba_ffz.sv =====
`default_nettype none

module ssba_ffz (
  input  wire logic [ssba_pkg::WORD_W-1:0] word_i,
  input  wire logic [ssba_pkg::WORD_W-1:0] mask_i,
  output ssba_pkg::ffz_t                   res_o
);
  import ssba_pkg::*;

  logic [WORD_W-1:0] clear_bits;
  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  idx;

  assign clear_bits = ~word_i & mask_i;
  assign lowest     = clear_bits & (~clear_bits + WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

  assign res_o.found  = |clear_bits;
  assign res_o.idx    = idx;
  assign res_o.onehot = lowest;

endmodule

`default_nettype wire

// ===== src/swap_slot_bitmap_allocator_core.sv =====
`default_nettype none

// Swap slot allocator over up to NUM_FILES backing files, one used bit per page kept in a
// 32-bit word memory with one read port and one write port. After reset the memory is swept
// to zero, one word a cycle, over all NUM_FILES * ceil(min(MAX_PAGES, 4096) / 32) words (512
// at the defaults); input is held off during the sweep while configuration writes are taken.
// An allocate scans the chosen file's bitmap one word per cycle through the memory read port
// with a single lowest-clear-bit encoder until a word holding a free page turns up. A free
// reads the word, then tests and writes back the bit, then finishes; no-space and
// bad-argument answers go straight to the finish state. One command is in flight at a time;
// each command gives one result word carrying the status and the total free page count. A new
// command is taken while the previous result word still waits; a command that reaches its
// finish state before that word is taken holds there until it is.
module swap_slot_bitmap_allocator_core #(
  parameter int unsigned NUM_FILES = ssba_pkg::NUM_FILES_DEF,
  parameter int unsigned MAX_PAGES = ssba_pkg::MAX_PAGES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // cfg write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ssba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ssba_pkg::PAGES_W-1:0]    cfg_data_i,
  // command stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ssba_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // free_entry[22:0], pad
  input  wire logic                            s_axis_tuser,  // cmd
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [ssba_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // alloc_entry[22:0],
                                                              // free_total[37:23], pad
  output logic [ssba_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);
  import ssba_pkg::*;

  localparam int unsigned PAGE_LIMIT = (MAX_PAGES < OFF_SPAN) ? MAX_PAGES : OFF_SPAN;
  localparam int unsigned WPF        = (PAGE_LIMIT + WORD_W - 1) / WORD_W;
  localparam int unsigned DEPTH      = NUM_FILES * WPF;
  localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW         = (WPF > 1) ? $clog2(WPF) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [PAGES_W-1:0]  pages_reg_q [CFG_FILES];
  logic [PAGES_W-1:0]  used_q [CFG_FILES];
  logic [PAGES_W-1:0]  used_d [CFG_FILES];
  logic [PAGES_W-1:0]  pages [CFG_FILES];
  logic [PAGES_W-1:0]  avail [CFG_FILES];
  logic [TOTAL_W-1:0]  free_sum;
  logic [FSEL_W-1:0]   fsel;

  logic [FSEL_W-1:0]   f_q, f_d;
  logic [PAGES_W-1:0]  p_q, p_d;
  logic [WW-1:0]       w_q, w_d;
  logic [BIT_W-1:0]    boff_q, boff_d;
  status_e             res_status_q, res_status_d;
  logic [ENTRY_W-1:0]  res_entry_q, res_entry_d;

  logic                m_valid_q, m_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ENTRY_W-1:0]  out_entry_q, out_entry_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [WORD_W-1:0]   scan_mask;
  ffz_t                ffz;

  logic                in_accept;
  logic [FILE_W-1:0]   in_file;
  logic [OFF_W-1:0]    in_off;
  logic                free_ok;

  function automatic logic [AW-1:0] addr_of(input logic [FSEL_W-1:0] f,
                                            input logic [31:0] w);
    logic [31:0] t;
    t = 32'(f) * 32'(WPF) + w;
    return t[AW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < CFG_FILES; i++) begin
      if (i < NUM_FILES) begin
        pages[i] = (pages_reg_q[i] > PAGES_W'(PAGE_LIMIT)) ? PAGES_W'(PAGE_LIMIT)
                                                           : pages_reg_q[i];
      end else begin
        pages[i] = '0;
      end
      avail[i] = (pages[i] > used_q[i]) ? (pages[i] - used_q[i]) : '0;
    end
  end

  always_comb begin
    free_sum = '0;
    for (int i = 0; i < CFG_FILES; i++) begin
      free_sum = free_sum + TOTAL_W'(avail[i]);
    end
  end

  always_comb begin
    fsel = '0;
    for (int i = CFG_FILES - 1; i >= 0; i--) begin
      if (avail[i] != '0) begin
        fsel = FSEL_W'(i);
      end
    end
  end

  assign in_file   = s_axis_tdata[FILE_W-1:0];
  assign in_off    = s_axis_tdata[OFF_LSB +: OFF_W];
  assign free_ok   = (32'(in_file) < NUM_FILES) && (32'(in_file) < CFG_FILES)
                  && (pages[in_file[FSEL_W-1:0]] != '0) && (32'(in_off) < PAGE_LIMIT);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // valid bits of the word under scan: offsets below the page count only
  always_comb begin
    logic [31:0] p_hi;
    logic [31:0] w32;
    p_hi = 32'(p_q >> BIT_W);
    w32  = 32'(w_q);
    if (w32 < p_hi) begin
      scan_mask = '1;
    end else if (w32 == p_hi) begin
      scan_mask = (WORD_W'(1) << p_q[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      scan_mask = '0;
    end
  end

  ssba_ffz u_ffz (
    .word_i (rd_data),
    .mask_i (scan_mask),
    .res_o  (ffz)
  );

  ssba_bitmap #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_comb begin
    logic [31:0] word_idx;
    logic [31:0] off32;
    logic [OFF_W-1:0] off12;
    state_d      = state_q;
    clr_d        = clr_q;
    used_d       = used_q;
    f_d          = f_q;
    p_d          = p_q;
    w_d          = w_q;
    boff_d       = boff_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_total_d  = out_total_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    word_idx     = 32'(in_off) >> BIT_W;
    off32        = (32'(w_q) << BIT_W) | 32'(ffz.idx);
    off12        = off32[OFF_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_entry_d = '0;
          if (s_axis_tuser == CMD_ALLOC) begin
            if (free_sum == '0) begin
              res_status_d = STAT_NOSPACE;
              state_d      = ST_FIN;
            end else begin
              f_d     = fsel;
              p_d     = pages[fsel];
              w_d     = '0;
              rd_en   = 1'b1;
              rd_addr = addr_of(fsel, 32'd0);
              state_d = ST_SCAN;
            end
          end else begin
            if (!free_ok) begin
              res_status_d = STAT_BADARG;
              state_d      = ST_FIN;
            end else begin
              f_d     = in_file[FSEL_W-1:0];
              w_d     = word_idx[WW-1:0];
              boff_d  = in_off[BIT_W-1:0];
              rd_en   = 1'b1;
              rd_addr = addr_of(in_file[FSEL_W-1:0], word_idx);
              state_d = ST_FREE;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = addr_of(f_q, 32'(w_q) + 32'd1);
        if (ffz.found) begin
          wr_en        = 1'b1;
          wr_addr      = addr_of(f_q, 32'(w_q));
          wr_data      = rd_data | ffz.onehot;
          used_d[f_q]  = used_q[f_q] + PAGES_W'(1);
          res_status_d = STAT_OK;
          res_entry_d  = {off12, 1'b1, 6'b0, FILE_W'(f_q)};
          state_d      = ST_FIN;
        end else begin
          w_d = w_q + WW'(1);
        end
      end
      ST_FREE: begin
        if (!rd_data[boff_q]) begin
          res_status_d = STAT_NOTALLOC;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = addr_of(f_q, 32'(w_q));
          wr_data      = rd_data & ~(WORD_W'(1) << boff_q);
          if (used_q[f_q] != '0) begin
            used_d[f_q] = used_q[f_q] - PAGES_W'(1);
          end
          res_status_d = STAT_OK;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_total_d  = free_sum;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < CFG_FILES; i++) begin
        used_q[i]      <= '0;
        pages_reg_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      used_q    <= used_d;
      if (cfg_valid_i && cfg_ready_o && (32'(cfg_index_i) < CFG_FILES)) begin
        pages_reg_q[cfg_index_i[FSEL_W-1:0]] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q          <= f_d;
    p_q          <= p_d;
    w_q          <= w_d;
    boff_q       <= boff_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_total_q  <= out_total_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - ENTRY_W - TOTAL_W)'(0), out_total_q, out_entry_q};

endmodule

`default_nettype wire

// ===== verif/swap_slot_bitmap_allocator_core_test.sv =====
`default_nettype none

module swap_slot_bitmap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssba_pkg::*;

  localparam int unsigned N_FILES    = NUM_FILES_DEF;
  localparam int unsigned PAGE_LIMIT = (MAX_PAGES_DEF < 4096) ? MAX_PAGES_DEF : 4096;
  localparam logic [ENTRY_W-1:0] ENTRY_MARK = 23'h400;
  localparam logic [ENTRY_W-1:0] KEY_MASK   = 23'h7FF80F;
  localparam logic [CFG_IDX_W-1:0] REG_FILE0_PAGES = 8'd0;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 210;

  typedef struct packed {
    status_e             status;
    logic [ENTRY_W-1:0]  alloc;
    logic [TOTAL_W-1:0]  total;
  } slot_result_t;

  class slot_scoreboard;
    logic [PAGES_W-1:0] pages_reg [CFG_FILES];
    bit                 used_map [N_FILES][PAGE_LIMIT];
    int unsigned        used_cnt [N_FILES];
    int unsigned        used_sum;
    slot_result_t       expected_q [$];
    logic [ENTRY_W-1:0] live_q [$];
    int                 errors;

    function new();
      foreach (pages_reg[i]) pages_reg[i] = '0;
      foreach (used_map[f, o]) used_map[f][o] = 1'b0;
      foreach (used_cnt[i]) used_cnt[i] = 0;
      used_sum = 0;
      errors = 0;
    endfunction

    function int unsigned pages_of(int unsigned f);
      int unsigned p;
      if (f >= CFG_FILES || f >= N_FILES) return 0;
      p = pages_reg[f];
      return (p > PAGE_LIMIT) ? PAGE_LIMIT : p;
    endfunction

    function int unsigned free_of(int unsigned f);
      int unsigned p;
      p = pages_of(f);
      return (p > used_cnt[f]) ? p - used_cnt[f] : 0;
    endfunction

    function int unsigned free_sum();
      int unsigned s;
      s = 0;
      for (int unsigned f = 0; f < N_FILES; f++) s += free_of(f);
      return s & 32'h7FFF;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [PAGES_W-1:0] val);
      if (idx < CFG_FILES) pages_reg[idx] = val;
    endfunction

    function void note_command(logic cmd, logic [ENTRY_W-1:0] entry);
      slot_result_t r;
      int unsigned  f;
      int unsigned  off;
      int unsigned  p;
      bit           done;
      int           hit;
      r.status = STAT_OK;
      r.alloc  = '0;
      if (cmd == CMD_ALLOC) begin
        if (free_sum() == 0) begin
          r.status = STAT_NOSPACE;
        end else begin
          done = 1'b0;
          for (f = 0; f < N_FILES && !done; f++) begin
            p = pages_of(f);
            if (free_of(f) != 0) begin
              for (off = 0; off < p && !done; off++) begin
                if (!used_map[f][off]) begin
                  used_map[f][off] = 1'b1;
                  used_cnt[f] = (used_cnt[f] + 1) & 32'h1FFF;
                  used_sum = (used_sum + 1) & 32'h7FFF;
                  r.alloc = ENTRY_W'(f | (off << OFF_LSB)) | ENTRY_MARK;
                  done = 1'b1;
                end
              end
            end
          end
          if (!done) r.status = STAT_NOSPACE;
          else live_q.push_back(r.alloc);
        end
      end else begin
        f   = entry[3:0];
        off = entry >> OFF_LSB;
        if (f >= N_FILES || pages_of(f) == 0 || off >= PAGE_LIMIT) begin
          r.status = STAT_BADARG;
        end else if (!used_map[f][off]) begin
          r.status = STAT_NOTALLOC;
        end else begin
          used_map[f][off] = 1'b0;
          if (used_cnt[f] > 0) used_cnt[f]--;
          if (used_sum > 0) used_sum--;
          hit = -1;
          foreach (live_q[i]) if ((live_q[i] & KEY_MASK) == (entry & KEY_MASK)) hit = i;
          if (hit >= 0) live_q.delete(hit);
        end
      end
      r.total = TOTAL_W'(free_sum());
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [ENTRY_W-1:0] ae,
                      logic [TOTAL_W-1:0] ft);
      slot_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing pending: status %0d entry %h total %0d",
                         st, ae, ft));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, wanted %0d", st, e.status));
      if (ae !== e.alloc)
        report($sformatf("alloc_entry %h, wanted %h", ae, e.alloc));
      if (ft !== e.total)
        report($sformatf("free_total %0d, wanted %0d", ft, e.total));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [PAGES_W-1:0]    cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  slot_scoreboard sb;
  int unsigned    tx_burst = 0;
  bit             tx_steady = 1'b0;
  int unsigned    rx_mode = 0;
  int unsigned    rx_left = 0;
  int unsigned    rx_stall = 0;

  swap_slot_bitmap_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    if (rx_stall != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 2) == 0);
        default: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_stall <= $urandom_range(5, 40);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[22:0], m_axis_tdata[37:23]);
  end

  function automatic logic [ENTRY_W-1:0] slot_entry(int unsigned f, int unsigned off);
    return ENTRY_W'(f | (off << OFF_LSB)) | ENTRY_MARK;
  endfunction

  function automatic int unsigned pick_pages();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2: return 32;
      3: return 33;
      4: return 4096;
      5: return 8191;
      6: return 4095;
      default: return $urandom_range(2, 70);
    endcase
  endfunction

  task automatic send_command(logic cmd, logic [ENTRY_W-1:0] entry);
    int unsigned gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 24);
      gap = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    tx_burst--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, entry};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, entry);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGES_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, val);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_files(int unsigned p0, int unsigned p1, int unsigned p2, int unsigned p3,
                           bit spare);
    logic [PAGES_W-1:0] vals [CFG_FILES];
    vals[0] = PAGES_W'(p0);
    vals[1] = PAGES_W'(p1);
    vals[2] = PAGES_W'(p2);
    vals[3] = PAGES_W'(p3);
    drain_results();
    for (int i = 0; i < CFG_FILES; i++) write_reg(REG_FILE0_PAGES + CFG_IDX_W'(i), vals[i]);
    if (spare) write_reg(CFG_IDX_W'($urandom_range(CFG_FILES, 255)), PAGES_W'($urandom));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned        r;
    int unsigned        alloc_pct;
    int unsigned        k;
    logic [ENTRY_W-1:0] e;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing configured yet
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, ENTRY_MARK);

    set_files(3, 0, 33, 8191, 1'b0);
    repeat (4) send_command(CMD_ALLOC, 23'h7FFFFF);
    send_command(CMD_FREE, slot_entry(0, 1));
    send_command(CMD_FREE, slot_entry(0, 1));
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, slot_entry(1, 0));
    send_command(CMD_FREE, slot_entry(4, 0));
    send_command(CMD_FREE, slot_entry(15, 0));
    send_command(CMD_FREE, slot_entry(0, 0) | 23'h7F0);
    send_command(CMD_FREE, slot_entry(3, 4095));
    send_command(CMD_FREE, 23'h7FFFFF);
    send_command(CMD_FREE, '0);

    // shrink file 0 below its use
    set_files(1, 0, 33, 8191, 1'b0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, slot_entry(0, 2));

    set_files(0, 0, 0, 0, 1'b0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, slot_entry(2, 0));

    set_files(8191, 4096, 4096, 4096, 1'b0);
    write_reg(8'd255, 13'h1FFF);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, slot_entry(2, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      set_files(pick_pages(), pick_pages(), pick_pages(), pick_pages(),
                $urandom_range(0, 1));
      tx_steady = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(35, 75);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_pct || (r < 90 && sb.live_q.size() == 0)) begin
          send_command(CMD_ALLOC, ENTRY_W'($urandom));
        end else if (r < 90) begin
          k = $urandom_range(0, sb.live_q.size() - 1);
          e = sb.live_q[k];
          if ($urandom_range(0, 3) == 0) e[10:4] = 7'($urandom);
          send_command(CMD_FREE, e);
        end else begin
          case ($urandom_range(0, 2))
            0: e = ENTRY_W'($urandom);
            1: e = {12'($urandom), 7'($urandom), 4'($urandom_range(0, 3))};
            default: e = {12'($urandom), 7'($urandom), 4'($urandom_range(4, 15))};
          endcase
          send_command(CMD_FREE, e);
        end
      end
    end

    drain_results();
    repeat (150) @(negedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("swap_slot_bitmap_allocator_core test passed");
    end else begin
      $display("swap_slot_bitmap_allocator_core test failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("swap_slot_bitmap_allocator_core test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/ssba_pkg.sv
src/ssba_bitmap.sv
src/ssba_ffz.sv
src/swap_slot_bitmap_allocator_core.sv
verif/swap_slot_bitmap_allocator_core_test.sv
